// ===== src/brace_hash_frame_receiver_defines.svh =====
// assertion macros for the brace hash frame receiver
`ifndef BRACE_HASH_FRAME_RECEIVER_DEFINES_SVH
`define BRACE_HASH_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BHFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BHFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bhfr_pkg.sv =====
// shared types and constants of the brace hash frame receiver
`timescale 1ns / 1ps
package bhfr_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_ORDER = 8'h4F;
  localparam logic [7:0] CH_RESP  = 8'h52;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd100;
  localparam int         QUEUE_DEPTH      = 2;

  localparam logic [1:0] CMD_EMIT  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_DROP  = 2'd2;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  localparam logic [1:0] FT_ORDER = 2'd0;
  localparam logic [1:0] FT_RESP  = 2'd1;
  localparam logic [1:0] FT_OTHER = 2'd2;

  localparam logic [1:0] PH_TYPE   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== src/brace_hash_frame_receiver.sv =====
// top level of the brace hash frame receiver
//
//   channel | handshake            | word
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | in_rx_byte
//   out     | out_valid / out_stall| out_kind, out_payload, out_frame_type,
//           |                      | out_message_id
//   cfg     | cfg_wr_en            | cfg_wr_data (max_length)
//
// one byte per cycle while in_stall is low; the front classifies a byte in its accept cycle
// a result word reaches the result register through the command queue after the byte that causes it is accepted
// synchronous reset restores max_length 100 and clears all frame state
// in_stall rises only while the command queue holds QDEPTH words
// out_stall holds the result register; the queue absorbs bytes meanwhile
`timescale 1ns / 1ps
`include "brace_hash_frame_receiver_defines.svh"
module brace_hash_frame_receiver #(
  parameter int QDEPTH = bhfr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload,
  output logic [1:0]  out_frame_type,
  output logic [31:0] out_message_id
);
  import bhfr_pkg::*;

  logic [7:0] max_length_r, max_length_nxt;
  logic       in_accept;
  logic       q_push, q_pop, q_empty, q_full;
  cmd_t       push_cmd, head_cmd;

  assign max_length_nxt = cfg_wr_en ? cfg_wr_data : max_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else begin
      max_length_r <= max_length_nxt;
    end
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  bhfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .max_length (max_length_r),
    .push       (q_push),
    .cmd        (push_cmd)
  );

  bhfr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  bhfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (!q_empty),
    .cmd            (head_cmd),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_frame_type (out_frame_type),
    .out_message_id (out_message_id)
  );

  `BHFR_ASSERT_NOW(a_push_not_full, q_push, !q_full, "command pushed into a full queue")
  `BHFR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "command popped from an empty queue")
  `BHFR_ASSERT_NOW(a_non_frame_zero, out_valid && (out_kind != KIND_FRAME), (out_frame_type == FT_ORDER) && (out_message_id == '0), "frame fields set on a non-frame word")
  `BHFR_ASSERT_NEXT(a_pop_loads_out, q_pop, out_valid, "popped command did not reach the result register")

endmodule

// ===== src/bhfr_front.sv =====
// front end: delimiter detection, length check and one-byte hold
`timescale 1ns / 1ps
module bhfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        max_length,
  output logic              push,
  output bhfr_pkg::cmd_t    cmd
);
  import bhfr_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       open_pair, close_pair;

  assign open_pair  = (rx_byte == CH_HASH) && (prev_r == CH_OPEN);
  assign close_pair = (rx_byte == CH_CLOSE) && (prev_r == CH_HASH);

  always_comb begin
    in_frame_nxt   = in_frame_r;
    prev_nxt       = prev_r;
    count_nxt      = count_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    push           = 1'b0;
    cmd.op         = CMD_EMIT;
    cmd.data       = held_r;
    if (accept) begin
      prev_nxt = rx_byte;
      if (open_pair || (in_frame_r && close_pair)) begin
        if (in_frame_r) begin
          push   = 1'b1;
          cmd.op = CMD_CLOSE;
        end
        in_frame_nxt   = !in_frame_r;
        count_nxt      = '0;
        held_valid_nxt = 1'b0;
      end else if (in_frame_r) begin
        if (count_r >= max_length) begin
          push           = 1'b1;
          cmd.op         = CMD_DROP;
          in_frame_nxt   = 1'b0;
          count_nxt      = '0;
          held_valid_nxt = 1'b0;
        end else begin
          push           = held_valid_r;
          held_nxt       = rx_byte;
          held_valid_nxt = 1'b1;
          count_nxt      = count_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      prev_r       <= '0;
      count_r      <= '0;
      held_valid_r <= 1'b0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      prev_r       <= prev_nxt;
      count_r      <= count_nxt;
      held_valid_r <= held_valid_nxt;
    end
    held_r <= held_nxt;
  end

endmodule

// ===== src/bhfr_queue.sv =====
// short command queue between front end and back end
`timescale 1ns / 1ps
module bhfr_queue #(
  parameter int DEPTH = bhfr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bhfr_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output bhfr_pkg::cmd_t    head_cmd,
  output logic              empty,
  output logic              full
);
  import bhfr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/bhfr_back.sv =====
// back end: type and id decode, result register
`timescale 1ns / 1ps
module bhfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  bhfr_pkg::cmd_t    cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_payload,
  output logic [1:0]        out_frame_type,
  output logic [31:0]       out_message_id
);
  import bhfr_pkg::*;

  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  pay_r, pay_nxt;
  logic [1:0]  ft_r, ft_nxt;
  logic [31:0] id_r, id_nxt;
  logic [1:0]  type_code_r, type_code_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [35:0] prod;
  logic        is_digit;

  assign pop      = cmd_valid && (!valid_r || !out_stall);
  assign is_digit = (cmd.data >= CH_ZERO) && (cmd.data <= CH_NINE);
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {28'd0, cmd.data - CH_ZERO};

  always_comb begin
    valid_nxt     = valid_r && out_stall;
    kind_nxt      = kind_r;
    pay_nxt       = pay_r;
    ft_nxt        = ft_r;
    id_nxt        = id_r;
    type_code_nxt = type_code_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    if (pop) begin
      valid_nxt = 1'b1;
      pay_nxt   = '0;
      ft_nxt    = FT_ORDER;
      id_nxt    = '0;
      case (cmd.op)
        CMD_EMIT: begin
          kind_nxt = KIND_PAYLOAD;
          pay_nxt  = cmd.data;
          case (phase_r)
            PH_TYPE: begin
              type_code_nxt = (cmd.data == CH_ORDER) ? FT_ORDER :
                              (cmd.data == CH_RESP)  ? FT_RESP  : FT_OTHER;
              phase_nxt     = PH_DIGITS;
            end
            PH_DIGITS: begin
              if (is_digit) begin
                acc_nxt = (prod[35:32] != 4'd0) ? '1 : prod[31:0];
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        CMD_CLOSE: begin
          kind_nxt      = KIND_FRAME;
          ft_nxt        = type_code_r;
          id_nxt        = acc_r;
          type_code_nxt = FT_OTHER;
          acc_nxt       = '0;
          phase_nxt     = PH_TYPE;
        end
        default: begin
          kind_nxt      = KIND_DROP;
          type_code_nxt = FT_OTHER;
          acc_nxt       = '0;
          phase_nxt     = PH_TYPE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      type_code_r <= FT_OTHER;
      acc_r       <= '0;
      phase_r     <= PH_TYPE;
    end else begin
      valid_r     <= valid_nxt;
      type_code_r <= type_code_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
    end
    kind_r <= kind_nxt;
    pay_r  <= pay_nxt;
    ft_r   <= ft_nxt;
    id_r   <= id_nxt;
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_payload    = pay_r;
  assign out_frame_type = ft_r;
  assign out_message_id = id_r;

endmodule

// ===== test/brace_hash_frame_receiver_checker.sv =====
// checker for the brace hash frame receiver: predicts each result word and compares it
`timescale 1ns / 1ps
module brace_hash_frame_receiver_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_payload,
  input  logic [1:0]  out_frame_type,
  input  logic [31:0] out_message_id,
  output int          mismatch_count,
  output int          results_pending
);
  import bhfr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [1:0]  frame_type;
    logic [31:0] message_id;
  } frame_word_t;

  logic [7:0]  limit_len;
  logic        framing;
  logic [7:0]  last_byte;
  logic [7:0]  stored_len;
  logic [7:0]  held;
  logic        held_ok;
  logic [1:0]  ftype;
  logic [31:0] id_value;
  logic [1:0]  id_state;
  frame_word_t predicted_words[$];

  function void clear_frame_state();
    stored_len = '0;
    held = '0;
    held_ok = 1'b0;
    ftype = FT_OTHER;
    id_value = '0;
    id_state = PH_TYPE;
  endfunction

  // type byte first, then decimal digits until the first non-digit
  function void decode_payload(input logic [7:0] c);
    logic [63:0] wide;
    if (id_state == PH_TYPE) begin
      ftype = (c == CH_ORDER) ? FT_ORDER : (c == CH_RESP) ? FT_RESP : FT_OTHER;
      id_state = PH_DIGITS;
    end else if (id_state == PH_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        wide = 64'(id_value) * 64'd10 + 64'(c - CH_ZERO);
        id_value = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      end else begin
        id_state = PH_DONE;
      end
    end
  endfunction

  function void predict_byte(input logic [7:0] b);
    logic opening;
    logic closing;
    opening = (b == CH_HASH) && (last_byte == CH_OPEN);
    closing = (b == CH_CLOSE) && (last_byte == CH_HASH);
    if (opening || (framing && closing)) begin
      if (framing) begin
        predicted_words.push_back('{KIND_FRAME, 8'd0, ftype, id_value});
        framing = 1'b0;
      end else begin
        framing = 1'b1;
      end
      clear_frame_state();
    end else if (framing) begin
      if (stored_len >= limit_len) begin
        predicted_words.push_back('{KIND_DROP, 8'd0, 2'd0, 32'd0});
        framing = 1'b0;
        clear_frame_state();
      end else begin
        if (held_ok) begin
          predicted_words.push_back('{KIND_PAYLOAD, held, 2'd0, 32'd0});
          decode_payload(held);
        end
        held = b;
        held_ok = 1'b1;
        stored_len = stored_len + 8'd1;
      end
    end
    last_byte = b;
  endfunction

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task check_word(input frame_word_t got);
    frame_word_t want;
    if (predicted_words.size() == 0) begin
      report_mismatch("result word with none predicted", 32'(got.kind), 32'd0);
    end else begin
      want = predicted_words.pop_front();
      if (got.kind != want.kind)
        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.payload != want.payload)
        report_mismatch("payload", 32'(got.payload), 32'(want.payload));
      if (got.frame_type != want.frame_type)
        report_mismatch("frame_type", 32'(got.frame_type), 32'(want.frame_type));
      if (got.message_id != want.message_id)
        report_mismatch("message_id", got.message_id, want.message_id);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_len = MAX_LENGTH_RESET;
      framing = 1'b0;
      last_byte = '0;
      clear_frame_state();
      predicted_words.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall)
        check_word('{out_kind, out_payload, out_frame_type, out_message_id});
      if (cfg_wr_en)
        limit_len = cfg_wr_data;
      if (in_valid && !in_stall)
        predict_byte(in_rx_byte);
    end
    results_pending <= predicted_words.size();
  end

endmodule

// ===== test/brace_hash_frame_receiver_test.sv =====
// testbench top for the brace hash frame receiver: stimulus, stalls and verdict
`timescale 1ns / 1ps
module brace_hash_frame_receiver_test;
  import bhfr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload;
  logic [1:0]  out_frame_type;
  logic [31:0] out_message_id;
  int          mismatch_count;
  int          results_pending;
  bit          calm = 1'b0;
  int          sent_bytes = 0;
  logic [7:0]  frame_limit = MAX_LENGTH_RESET;

  always #10 clk = ~clk;

  brace_hash_frame_receiver u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_frame_type (out_frame_type),
    .out_message_id (out_message_id)
  );

  brace_hash_frame_receiver_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_payload     (out_payload),
    .out_frame_type  (out_frame_type),
    .out_message_id  (out_message_id),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // hold off until every predicted word is out and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frame_limit = v;
  endtask

  task automatic send_frame();
    int pick;
    int len;
    int digits;
    logic [7:0] b;
    pick = $urandom_range(0, 9);
    calm = ($urandom_range(0, 5) == 0);
    if (pick < 7) begin
      send_text("{#");
      if (frame_limit <= 20 && $urandom_range(0, 3) == 0)
        len = frame_limit + $urandom_range(0, 2);
      else
        len = $urandom_range(0, 20);
      digits = $urandom_range(0, 12);
      for (int n = 0; n < len; n++) begin
        if (n == 0) begin
          case ($urandom_range(0, 2))
            0: b = CH_ORDER;
            1: b = CH_RESP;
            default: b = 8'($urandom_range(0, 255));
          endcase
        end else if (n <= digits) begin
          b = CH_ZERO + 8'($urandom_range(0, 9));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_byte(b);
      end
      if ($urandom_range(0, 1) == 0)
        send_text("#}");
      else
        send_text("{#");
    end else if (pick < 9) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: b = CH_OPEN;
          1: b = CH_HASH;
          2: b = CH_CLOSE;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b);
      end
    end else begin
      send_text("{#");
      repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int amount);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < amount) send_frame();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // ignored bytes, order with saturated id, response closed by an open pair, empty frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CLOSE);
    send_text("{#O4294967296#}");
    send_text("{#R7{#");
    send_text("{##}");
    run_random(30);

    set_limit(8'd255);
    calm = 1'b1;
    send_text("{#");
    repeat (257) send_byte(8'($urandom_range(0, 255)));
    run_random(30);

    set_limit(8'd1);
    send_text("{#ab#}");
    run_random(30);

    set_limit(8'd0);
    send_text("{#x#}");
    run_random(20);

    set_limit(8'($urandom_range(2, 12)));
    run_random(40);

    set_limit(8'($urandom_range(13, 254)));
    run_random(40);

    settle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    forever begin
      int hold;
      hold = 0;
      forever begin
        @(negedge clk);
        if (hold > 0) begin
          out_stall <= 1'b1;
          hold--;
        end else begin
          out_stall <= 1'b0;
          @(posedge clk);
          if (out_valid)
            hold = calm ? 0 : $urandom_range(0, 13);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/bhfr_pkg.sv
src/bhfr_front.sv
src/bhfr_queue.sv
src/bhfr_back.sv
src/brace_hash_frame_receiver.sv
test/brace_hash_frame_receiver_checker.sv
test/brace_hash_frame_receiver_test.sv
